// ===== rtl/mxu_pkg.sv =====
package mxu_pkg;

	// instruction codes as carried in the func field
	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_ADDI = 4'd2,
		OP_SUBI = 4'd3,
		OP_OR   = 4'd4,
		OP_AND  = 4'd5,
		OP_SLL  = 4'd6,
		OP_SRL  = 4'd7,
		OP_LW   = 4'd8,
		OP_SW   = 4'd9,
		OP_LBU  = 4'd10,
		OP_SBU  = 4'd11,
		OP_J    = 4'd12,
		OP_BEQ  = 4'd13,
		OP_BNE  = 4'd14,
		OP_SLT  = 4'd15
	} op_t;

	// register file read ports
	localparam int RD_PORTS = 3;
	localparam int RP_RS    = 0;
	localparam int RP_RT    = 1;
	localparam int RP_RD    = 2;

	// configuration space
	localparam int                CFG_AW         = 2;
	localparam logic [CFG_AW-1:0] ADDR_COST_MODE = CFG_AW'(0);

	localparam logic [15:0] PC_STEP     = 16'd4;
	localparam int          MEM_INDEX_W = 10;
	localparam int          BYTE_BITS   = 8;

	localparam logic [2:0] COST_SINGLE = 3'd1;
	localparam logic [2:0] COST_ALU    = 3'd4;
	localparam logic [2:0] COST_LOAD   = 3'd5;
	localparam logic [2:0] COST_STORE  = 3'd4;
	localparam logic [2:0] COST_JUMP   = 3'd1;
	localparam logic [2:0] COST_BRANCH = 3'd3;

	typedef struct packed {
		logic [3:0]         func;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg;
		logic [4:0]         src2_reg;
		logic signed [15:0] immediate;
		logic [15:0]        target_pc;
	} in_item_t;

	typedef struct packed {
		logic [15:0]              next_pc;
		logic                     branch_taken;
		logic                     reg_written;
		logic [4:0]               written_reg;
		logic signed [31:0]       written_value;
		logic                     mem_written;
		logic [MEM_INDEX_W-1:0]   mem_index;
		logic [2:0]               cycles_added;
		logic [31:0]              cycle_total;
	} out_item_t;

	// control flags that travel with an instruction down the pipe
	typedef struct packed {
		logic wr;       // register write
		logic mw;       // memory write
		logic mem_op;   // load or store
		logic byte_op;  // byte-wide load or store
		logic taken;    // pc loads target
	} ctl_t;

	// multi-cycle datapath cost per instruction
	function automatic logic [2:0] multi_cost(op_t op);
		logic [2:0] c;
		unique case (op)
			OP_ADD, OP_SUB, OP_ADDI, OP_SUBI, OP_OR, OP_AND,
			OP_SLL, OP_SRL, OP_SLT:    c = COST_ALU;
			OP_LW, OP_LBU:             c = COST_LOAD;
			OP_SW, OP_SBU:             c = COST_STORE;
			OP_J:                      c = COST_JUMP;
			OP_BEQ, OP_BNE:            c = COST_BRANCH;
		endcase
		return c;
	endfunction

	// which register read ports an instruction depends on
	function automatic logic [RD_PORTS-1:0] operand_need(op_t op);
		logic [RD_PORTS-1:0] n;
		n = '0;
		unique case (op)
			OP_ADD, OP_SUB, OP_OR, OP_AND, OP_SLT: begin
				n[RP_RS] = 1'b1;
				n[RP_RT] = 1'b1;
			end
			OP_ADDI, OP_SUBI, OP_SLL, OP_SRL, OP_LW, OP_LBU: begin
				n[RP_RS] = 1'b1;
			end
			OP_SW, OP_SBU, OP_BEQ, OP_BNE: begin
				n[RP_RS] = 1'b1;
				n[RP_RD] = 1'b1;
			end
			OP_J: begin
				n = '0;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/mxu_if.sv =====
interface mxu_in_if import mxu_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mxu_out_if import mxu_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/mxu_ram.sv =====
module mxu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mxu_regfile.sv =====
module mxu_regfile import mxu_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int REG_COUNT = 32,
	localparam int RIW = $clog2(REG_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [RIW-1:0]       raddr [RD_PORTS],
	output logic [WORD_BITS-1:0] rdata [RD_PORTS],
	input  logic                 we,
	input  logic [RIW-1:0]       waddr,
	input  logic [WORD_BITS-1:0] wdata
);

	logic [RIW-1:0]       raddr_q [RD_PORTS];
	logic [WORD_BITS-1:0] ram_rdata [RD_PORTS];
	logic [REG_COUNT-1:0] vld_q;
	logic                 bp_v_q;
	logic [RIW-1:0]       bp_idx_q;
	logic [WORD_BITS-1:0] bp_data_q;

	// never-written entries read as zero; the last write covers a same-edge read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			bp_v_q <= 1'b0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
			bp_v_q       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		raddr_q <= raddr;
		if (we) begin
			bp_idx_q  <= waddr;
			bp_data_q <= wdata;
		end
	end

	for (genvar p = 0; p < RD_PORTS; p++) begin : g_port
		mxu_ram #(
			.WIDTH(WORD_BITS),
			.DEPTH(REG_COUNT)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(wdata),
			.raddr(raddr[p]),
			.rdata(ram_rdata[p])
		);

		always_comb begin
			priority if (bp_v_q && bp_idx_q == raddr_q[p]) begin
				rdata[p] = bp_data_q;
			end else if (vld_q[raddr_q[p]]) begin
				rdata[p] = ram_rdata[p];
			end else begin
				rdata[p] = '0;
			end
		end
	end

endmodule

// ===== rtl/mxu_alu.sv =====
module mxu_alu import mxu_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  op_t                  op,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] d,
	input  logic signed [15:0]   imm,
	output ctl_t                 ctl,
	output logic [WORD_BITS-1:0] val,
	output logic [WORD_BITS-1:0] sdata,
	output logic [31:0]          addr_sum
);

	logic [WORD_BITS-1:0] immx;
	logic [4:0]           sh;
	logic                 lt;

	assign immx     = WORD_BITS'(imm);
	assign sh       = imm[4:0];
	assign lt       = $signed(a) < $signed(b);
	// byte address before wrapping to the memory depth
	assign addr_sum = 32'(a) + 32'(imm);

	always_comb begin
		ctl   = '0;
		val   = '0;
		sdata = d;
		unique case (op)
			OP_ADD: begin
				ctl.wr = 1'b1;
				val    = a + b;
			end
			OP_SUB: begin
				ctl.wr = 1'b1;
				val    = a - b;
			end
			OP_ADDI: begin
				ctl.wr = 1'b1;
				val    = a + immx;
			end
			OP_SUBI: begin
				ctl.wr = 1'b1;
				val    = a - immx;
			end
			OP_OR: begin
				ctl.wr = 1'b1;
				val    = a | b;
			end
			OP_AND: begin
				ctl.wr = 1'b1;
				val    = a & b;
			end
			OP_SLL: begin
				ctl.wr = 1'b1;
				val    = a << sh;
			end
			OP_SRL: begin
				ctl.wr = 1'b1;
				val    = a >> sh;
			end
			OP_LW: begin
				ctl.wr     = 1'b1;
				ctl.mem_op = 1'b1;
			end
			OP_SW: begin
				ctl.mw     = 1'b1;
				ctl.mem_op = 1'b1;
			end
			OP_LBU: begin
				ctl.wr      = 1'b1;
				ctl.mem_op  = 1'b1;
				ctl.byte_op = 1'b1;
			end
			OP_SBU: begin
				ctl.mw      = 1'b1;
				ctl.mem_op  = 1'b1;
				ctl.byte_op = 1'b1;
				sdata       = WORD_BITS'(d[BYTE_BITS-1:0]);
			end
			OP_J: begin
				ctl.taken = 1'b1;
			end
			OP_BEQ: begin
				ctl.taken = (d == a);
			end
			OP_BNE: begin
				ctl.taken = (d != a);
			end
			OP_SLT: begin
				ctl.wr = 1'b1;
				val    = {{(WORD_BITS-1){1'b0}}, lt};
			end
		endcase
	end

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// a result beat passes s1, s2, s3 and s4 into the result register after its instruction beat is taken
// throughput: one instruction per cycle while the result port takes beats; a consumer
//   of a load within the next two instructions waits in s1 for the registered data memory read
// reset: asynchronous, active low; after release the data memory is zeroed one entry at a
//   time, and no instruction beat is taken while it is being zeroed
module mips_subset_execute_unit import mxu_pkg::*; #(
	parameter int DATA_DEPTH = 1024,
	parameter int REG_COUNT  = 32,
	parameter int WORD_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	mxu_in_if.sink            instr,
	mxu_out_if.source         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int RIW = $clog2(REG_COUNT);
	localparam int AW  = $clog2(DATA_DEPTH);
	// reciprocal for the address wrap: q = floor(x * RECIP / 2^ML) is at most one short
	localparam int          ML      = 32 + AW;
	localparam logic [64:0] RECIP   = (65'd1 << ML) / 65'(DATA_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DATA_DEPTH);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(DATA_DEPTH - 1);

	typedef struct packed {
		op_t                  op;
		ctl_t                 ctl;
		logic [RIW-1:0]       rd;
		logic [WORD_BITS-1:0] val;
		logic [WORD_BITS-1:0] sdata;
		logic [15:0]          target;
		logic [31:0]          addr;
	} ex_t;

	// register index wrap, a few compare-subtract steps on a five-bit value
	function automatic logic [RIW-1:0] reg_of(logic [4:0] r);
		logic [5:0] t;
		t = {1'b0, r};
		for (int k = 0; k < 4; k++) begin
			if (t >= 6'(REG_COUNT)) begin
				t = t - 6'(REG_COUNT);
			end
		end
		return RIW'(t);
	endfunction

	// ---------------------------------------------------------------------
	// architectural state and configuration
	// ---------------------------------------------------------------------
	logic        cost_mode_q;
	logic [15:0] pc_q;
	logic [31:0] cycle_q;
	logic        clearing_q;
	logic [AW-1:0] clr_q;

	// ---------------------------------------------------------------------
	// pipeline registers
	// s1: operand read, s2: reciprocal multiply, s3: address wrap and
	// memory read, s4: load data and commit, then the result register
	// ---------------------------------------------------------------------
	logic                 v_s1, v_s2, v_s3, v_s4;
	op_t                  op_s1;
	logic [RIW-1:0]       idx_s1 [RD_PORTS];
	logic signed [15:0]   imm_s1;
	logic [15:0]          target_s1;
	ex_t                  ex_s2, ex_s3, ex_s4;
	logic [AW:0]          q_s3;
	logic [AW-1:0]        midx_s4;
	logic                 out_v_q;
	out_item_t            out_q;

	// handshake and stage moves
	logic out_free, go_s4, free_s4, go_s3, free_s3, go_s2, free_s2, go_s1, free_s1;
	logic acc, hazard;

	assign out_free = !out_v_q || result.ready;
	assign go_s4    = v_s4 && out_free;
	assign free_s4  = !v_s4 || go_s4;
	assign go_s3    = v_s3 && free_s4;
	assign free_s3  = !v_s3 || go_s3;
	assign go_s2    = v_s2 && free_s3;
	assign free_s2  = !v_s2 || go_s2;
	assign go_s1    = v_s1 && free_s2 && !hazard;
	assign free_s1  = !v_s1 || go_s1;

	// no beats while the data memory is being zeroed
	assign instr.ready = free_s1 && !clearing_q;
	assign acc         = instr.valid && instr.ready;

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_COST_MODE);
	assign prdata = (paddr == ADDR_COST_MODE) ? 32'(cost_mode_q) : '0;

	// ---------------------------------------------------------------------
	// register file: read addresses follow the new beat, or hold for s1
	// ---------------------------------------------------------------------
	logic [RIW-1:0]       new_idx  [RD_PORTS];
	logic [RIW-1:0]       rf_raddr [RD_PORTS];
	logic [WORD_BITS-1:0] rf_rdata [RD_PORTS];
	logic                 rf_we;
	logic [WORD_BITS-1:0] val_s4;

	assign new_idx[RP_RS] = reg_of(instr.data.src_reg);
	assign new_idx[RP_RT] = reg_of(instr.data.src2_reg);
	assign new_idx[RP_RD] = reg_of(instr.data.dest_reg);

	always_comb begin
		for (int p = 0; p < RD_PORTS; p++) begin
			rf_raddr[p] = acc ? new_idx[p] : idx_s1[p];
		end
	end

	assign rf_we = go_s4 && ex_s4.ctl.wr;

	mxu_regfile #(
		.WORD_BITS(WORD_BITS),
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (rf_raddr),
		.rdata (rf_rdata),
		.we    (rf_we),
		.waddr (ex_s4.rd),
		.wdata (val_s4)
	);

	// ---------------------------------------------------------------------
	// operand forwarding from writes still in flight, youngest first;
	// a load in s2 or s3 has no data yet, so its consumer waits in s1
	// ---------------------------------------------------------------------
	logic [WORD_BITS-1:0] opnd [RD_PORTS];
	logic [RD_PORTS-1:0]  need_s1;

	assign need_s1 = operand_need(op_s1);

	always_comb begin
		hazard = 1'b0;
		for (int p = 0; p < RD_PORTS; p++) begin
			priority if (v_s2 && ex_s2.ctl.wr && ex_s2.rd == idx_s1[p]) begin
				opnd[p] = ex_s2.val;
				if (need_s1[p] && ex_s2.ctl.mem_op) begin
					hazard = 1'b1;
				end
			end else if (v_s3 && ex_s3.ctl.wr && ex_s3.rd == idx_s1[p]) begin
				opnd[p] = ex_s3.val;
				if (need_s1[p] && ex_s3.ctl.mem_op) begin
					hazard = 1'b1;
				end
			end else if (v_s4 && ex_s4.ctl.wr && ex_s4.rd == idx_s1[p]) begin
				opnd[p] = val_s4;
			end else begin
				opnd[p] = rf_rdata[p];
			end
		end
	end

	// ---------------------------------------------------------------------
	// s1 execute
	// ---------------------------------------------------------------------
	ctl_t                 alu_ctl;
	logic [WORD_BITS-1:0] alu_val, alu_sdata;
	logic [31:0]          alu_addr;

	mxu_alu #(
		.WORD_BITS(WORD_BITS)
	) u_alu (
		.op      (op_s1),
		.a       (opnd[RP_RS]),
		.b       (opnd[RP_RT]),
		.d       (opnd[RP_RD]),
		.imm     (imm_s1),
		.ctl     (alu_ctl),
		.val     (alu_val),
		.sdata   (alu_sdata),
		.addr_sum(alu_addr)
	);

	// ---------------------------------------------------------------------
	// address wrap to the memory depth: multiply in s2, fix-up in s3
	// ---------------------------------------------------------------------
	logic [64:0] prod_s2;
	logic [AW:0] qd_s3, rraw_s3;
	logic [AW-1:0] midx_s3;

	assign prod_s2 = 65'(ex_s2.addr) * RECIP;
	assign qd_s3   = q_s3 * DEPTH_W;
	assign rraw_s3 = ex_s3.addr[AW:0] - qd_s3;
	assign midx_s3 = AW'((rraw_s3 >= DEPTH_W) ? (rraw_s3 - DEPTH_W) : rraw_s3);

	// ---------------------------------------------------------------------
	// data memory: read issued as s3 moves on, held while s4 waits;
	// the last store covers a read on the same edge
	// ---------------------------------------------------------------------
	logic                 dm_we;
	logic [AW-1:0]        dm_waddr, dm_raddr;
	logic [WORD_BITS-1:0] dm_wdata, dm_rdata, ld_word;
	logic                 st_v_q;
	logic [AW-1:0]        st_idx_q;
	logic [WORD_BITS-1:0] st_data_q;

	assign dm_we    = clearing_q || (go_s4 && ex_s4.ctl.mw);
	assign dm_waddr = clearing_q ? clr_q : midx_s4;
	assign dm_wdata = clearing_q ? '0 : ex_s4.sdata;
	assign dm_raddr = go_s3 ? midx_s3 : midx_s4;

	mxu_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DATA_DEPTH)
	) u_dmem (
		.clk  (clk),
		.we   (dm_we),
		.waddr(dm_waddr),
		.wdata(dm_wdata),
		.raddr(dm_raddr),
		.rdata(dm_rdata)
	);

	assign ld_word = (st_v_q && st_idx_q == midx_s4) ? st_data_q : dm_rdata;

	always_comb begin
		priority if (ex_s4.ctl.wr && ex_s4.ctl.mem_op) begin
			val_s4 = ex_s4.ctl.byte_op ? WORD_BITS'(ld_word[BYTE_BITS-1:0]) : ld_word;
		end else begin
			val_s4 = ex_s4.val;
		end
	end

	// ---------------------------------------------------------------------
	// commit values
	// ---------------------------------------------------------------------
	logic [15:0] nxt_pc;
	logic [2:0]  cost_s4;
	logic [31:0] nxt_total;

	assign nxt_pc    = ex_s4.ctl.taken ? ex_s4.target : pc_q + PC_STEP;
	assign cost_s4   = cost_mode_q ? multi_cost(ex_s4.op) : COST_SINGLE;
	assign nxt_total = cycle_q + 32'(cost_s4);

	// ---------------------------------------------------------------------
	// control state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_v_q     <= 1'b0;
			cost_mode_q <= 1'b0;
			pc_q        <= '0;
			cycle_q     <= '0;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			st_v_q      <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= acc;
			end
			if (free_s2) begin
				v_s2 <= go_s1;
			end
			if (free_s3) begin
				v_s3 <= go_s2;
			end
			if (free_s4) begin
				v_s4 <= go_s3;
			end
			if (out_free) begin
				out_v_q <= go_s4;
			end
			if (cfg_we) begin
				cost_mode_q <= pwdata[0];
			end
			if (go_s4) begin
				pc_q    <= nxt_pc;
				cycle_q <= nxt_total;
			end
			if (go_s4 && ex_s4.ctl.mw) begin
				st_v_q <= 1'b1;
			end
			// zeroing sweep, one entry a cycle
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == LAST_ENTRY) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// payload
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= op_t'(instr.data.func);
			idx_s1    <= new_idx;
			imm_s1    <= instr.data.immediate;
			target_s1 <= instr.data.target_pc;
		end
		if (go_s1) begin
			ex_s2.op     <= op_s1;
			ex_s2.ctl    <= alu_ctl;
			ex_s2.rd     <= idx_s1[RP_RD];
			ex_s2.val    <= alu_val;
			ex_s2.sdata  <= alu_sdata;
			ex_s2.target <= target_s1;
			ex_s2.addr   <= alu_addr;
		end
		if (go_s2) begin
			ex_s3 <= ex_s2;
			q_s3  <= prod_s2[ML +: AW + 1];
		end
		if (go_s3) begin
			ex_s4   <= ex_s3;
			midx_s4 <= midx_s3;
		end
		if (go_s4 && ex_s4.ctl.mw) begin
			st_idx_q  <= midx_s4;
			st_data_q <= ex_s4.sdata;
		end
		if (go_s4) begin
			out_q.next_pc       <= nxt_pc;
			out_q.branch_taken  <= ex_s4.ctl.taken;
			out_q.reg_written   <= ex_s4.ctl.wr;
			out_q.written_reg   <= ex_s4.ctl.wr ? 5'(ex_s4.rd) : '0;
			out_q.written_value <= ex_s4.ctl.wr ? 32'(signed'(val_s4)) : '0;
			out_q.mem_written   <= ex_s4.ctl.mw;
			out_q.mem_index     <= ex_s4.ctl.mem_op ? MEM_INDEX_W'(midx_s4) : '0;
			out_q.cycles_added  <= cost_s4;
			out_q.cycle_total   <= nxt_total;
		end
	end

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	// pipe stays empty while the data memory is being zeroed
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s1 && !v_s2 && !v_s3 && !v_s4)
		else $error("instruction in flight during memory clear");

	// a wait in s1 only ever comes from a load still short of data
	a_hazard_src: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |-> (v_s2 && ex_s2.ctl.wr && ex_s2.ctl.mem_op) ||
		           (v_s3 && ex_s3.ctl.wr && ex_s3.ctl.mem_op))
		else $error("s1 held without a pending load");

	// a held s1 instruction is not lost and keeps its op and immediate
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !go_s1 |=> v_s1 && $stable(op_s1) && $stable(imm_s1))
		else $error("s1 instruction lost while held");

	// pc and cycle total move only on commit
	a_state_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!go_s4 |=> $stable(pc_q) && $stable(cycle_q))
		else $error("architectural state changed without commit");

	// a commit always lands in the result register
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		go_s4 |=> out_v_q)
		else $error("committed instruction produced no result beat");

endmodule
